FILE: rtl/core/udc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udc_pkg
// Shared types and constants for the UDP datagram checker: the byte item,
// the result item, and the records passed between the pipeline stages.
// ----------------------------------------------------------------------------
package udc_pkg;

  localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
  localparam logic [15:0] UDP_PROTO     = 16'd17;
  localparam logic [15:0] WORD_MASK     = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  // Header byte positions within the first eight bytes.
  localparam logic [2:0] POS_SPORT_HI = 3'd0;
  localparam logic [2:0] POS_SPORT_LO = 3'd1;
  localparam logic [2:0] POS_DPORT_HI = 3'd2;
  localparam logic [2:0] POS_DPORT_LO = 3'd3;
  localparam logic [2:0] POS_LEN_HI   = 3'd4;
  localparam logic [2:0] POS_LEN_LO   = 3'd5;
  localparam logic [2:0] POS_CSUM_HI  = 3'd6;
  localparam logic [2:0] POS_CSUM_LO  = 3'd7;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] source_address;
    logic [31:0] destination_address;
  } udc_item_t;

  typedef struct packed {
    logic        header_ok;
    logic        checksum_ok;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [15:0] length_field;
    logic [15:0] stored_checksum;
    logic [15:0] received_count;
  } udc_result_t;

  // Everything gathered for one datagram when its last byte is taken.
  // The sum already holds the address words of the pseudo-header.
  typedef struct packed {
    logic [15:0] count;
    logic [31:0] sum;
    logic [7:0]  held;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] len;
    logic [15:0] csum;
  } udc_dgram_t;

  // First finishing stage: flags settled, checksum split into two partial sums.
  typedef struct packed {
    logic        hdr_ok;
    logic        zero_ok;
    logic        verify;
    logic [31:0] data_sum;
    logic [18:0] hdr_sum;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] len;
    logic [15:0] csum;
    logic [15:0] count;
  } udc_stage_t;

endpackage

FILE: rtl/core/udc_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udc_accum
// Per-byte datagram state: byte count, header capture and running sum.
// On the last byte it hands the gathered record to the finishing stages.
// ----------------------------------------------------------------------------
module udc_accum
  import udc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  udc_item_t  item,
  output logic       item_ready,
  input  logic       down_free,
  output logic       dgram_valid,
  output udc_dgram_t dgram
);

  logic [15:0] byte_count;
  logic [31:0] running_sum;
  logic [7:0]  held_high_byte;
  logic [15:0] captured_source_port;
  logic [15:0] captured_destination_port;
  logic [15:0] captured_length;
  logic [15:0] captured_checksum;

  udc_dgram_t upd;
  logic       dgram_free;
  logic       take;

  assign dgram_free = !dgram_valid || down_free;
  assign item_ready = !item.last_byte || dgram_free;
  assign take       = item_valid && item_ready;

  always_comb begin
    upd.count = byte_count;
    upd.sum   = running_sum;
    upd.held  = held_high_byte;
    upd.sport = captured_source_port;
    upd.dport = captured_destination_port;
    upd.len   = captured_length;
    upd.csum  = captured_checksum;

    // The address words of the pseudo-header enter the sum with the first byte,
    // while the sum is still clear.
    if (byte_count == 16'd0) begin
      upd.sum = 32'(item.source_address[31:16]) + 32'(item.source_address[15:0])
              + 32'(item.destination_address[31:16])
              + 32'(item.destination_address[15:0]);
    end

    if (byte_count < UDP_HDR_BYTES) begin
      unique case (byte_count[2:0])
        POS_SPORT_HI: upd.sport[15:8] = item.data_byte;
        POS_SPORT_LO: upd.sport[7:0]  = item.data_byte;
        POS_DPORT_HI: upd.dport[15:8] = item.data_byte;
        POS_DPORT_LO: upd.dport[7:0]  = item.data_byte;
        POS_LEN_HI:   upd.len[15:8]   = item.data_byte;
        POS_LEN_LO:   upd.len[7:0]    = item.data_byte;
        POS_CSUM_HI:  upd.csum[15:8]  = item.data_byte;
        POS_CSUM_LO:  upd.csum[7:0]   = item.data_byte;
      endcase
    end else if (byte_count < captured_length) begin
      if (!byte_count[0]) begin
        upd.held = item.data_byte;
      end else begin
        upd.sum = running_sum + 32'({held_high_byte, item.data_byte});
      end
    end

    if (byte_count != COUNT_MAX) begin
      upd.count = byte_count + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count                <= '0;
      running_sum               <= '0;
      held_high_byte            <= '0;
      captured_source_port      <= '0;
      captured_destination_port <= '0;
      captured_length           <= '0;
      captured_checksum         <= '0;
    end else if (take) begin
      if (item.last_byte) begin
        byte_count                <= '0;
        running_sum               <= '0;
        held_high_byte            <= '0;
        captured_source_port      <= '0;
        captured_destination_port <= '0;
        captured_length           <= '0;
        captured_checksum         <= '0;
      end else begin
        byte_count                <= upd.count;
        running_sum               <= upd.sum;
        held_high_byte            <= upd.held;
        captured_source_port      <= upd.sport;
        captured_destination_port <= upd.dport;
        captured_length           <= upd.len;
        captured_checksum         <= upd.csum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dgram_valid <= 1'b0;
    end else if (take && item.last_byte) begin
      dgram_valid <= 1'b1;
    end else if (down_free) begin
      dgram_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.last_byte) begin
      dgram <= upd;
    end
  end

endmodule

FILE: rtl/core/udc_final.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udc_final
// Two finishing stages: length checks and partial checksum sums, then the
// final add, end-around carry fold and compare into the result register.
// ----------------------------------------------------------------------------
module udc_final
  import udc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        dgram_valid,
  input  udc_dgram_t  dgram,
  output logic        down_free,
  output logic        result_valid,
  input  logic        result_ready,
  output udc_result_t result
);

  udc_stage_t  stage_next;
  udc_stage_t  stage;
  logic        stage_valid;
  logic        out_free;
  logic        stage_load;
  logic        out_load;
  logic [18:0] hdr_words;
  logic [31:0] total;
  logic [16:0] fold_a;
  logic [15:0] fold_b;

  assign out_free   = !result_valid || result_ready;
  assign down_free  = !stage_valid || out_free;
  assign stage_load = dgram_valid && down_free;
  assign out_load   = stage_valid && out_free;

  // Header words count only as far as the claimed length reaches; a word cut
  // in half keeps its high byte.
  always_comb begin
    logic [15:0] words [4];
    words[0] = dgram.sport;
    words[1] = dgram.dport;
    words[2] = dgram.len;
    words[3] = dgram.csum;
    hdr_words = '0;
    for (int k = 0; k < 4; k++) begin
      if (dgram.len >= 16'(2 * k + 2)) begin
        hdr_words = hdr_words + 19'(words[k]);
      end else if (dgram.len == 16'(2 * k + 1)) begin
        hdr_words = hdr_words + 19'({words[k][15:8], 8'h00});
      end
    end
  end

  always_comb begin
    stage_next.hdr_ok  = (dgram.count >= UDP_HDR_BYTES) && (dgram.len >= UDP_HDR_BYTES)
                         && (dgram.len <= dgram.count);
    stage_next.zero_ok = (dgram.count >= UDP_HDR_BYTES) && (dgram.csum == 16'd0);
    stage_next.verify  = (dgram.count >= UDP_HDR_BYTES) && (dgram.csum != 16'd0)
                         && (dgram.len <= dgram.count);
    // An odd length past the header leaves a high byte waiting for its pad.
    if (dgram.len > UDP_HDR_BYTES && dgram.len[0]) begin
      stage_next.data_sum = dgram.sum + 32'({dgram.held, 8'h00});
    end else begin
      stage_next.data_sum = dgram.sum;
    end
    stage_next.hdr_sum = hdr_words + 19'(UDP_PROTO) + 19'(dgram.len);
    stage_next.sport   = dgram.sport;
    stage_next.dport   = dgram.dport;
    stage_next.len     = dgram.len;
    stage_next.csum    = dgram.csum;
    stage_next.count   = dgram.count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_load) begin
      stage_valid <= 1'b1;
    end else if (out_free) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_load) begin
      stage <= stage_next;
    end
  end

  // The total is never zero, since the protocol and length words are in it,
  // so the folded sum is all ones exactly when the total is a multiple of
  // 0xFFFF. Two folds bring a 32-bit total down to 16 bits.
  assign total  = stage.data_sum + 32'(stage.hdr_sum);
  assign fold_a = {1'b0, total[15:0]} + {1'b0, total[31:16]};
  assign fold_b = fold_a[15:0] + 16'(fold_a[16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.header_ok        <= stage.hdr_ok;
      result.checksum_ok      <= stage.zero_ok || (stage.verify && fold_b == WORD_MASK);
      result.source_port      <= stage.sport;
      result.destination_port <= stage.dport;
      result.length_field     <= stage.len;
      result.stored_checksum  <= stage.csum;
      result.received_count   <= stage.count;
    end
  end

endmodule

FILE: rtl/core/udp_datagram_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_datagram_checker
// Verifies the length field and the checksum of received UDP datagrams.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel carries one datagram byte per transfer, header first,
//   with last_byte set on the final byte. The IPv4 source and destination
//   addresses are sampled with the first byte of each datagram only.
//   The result channel carries one transfer per datagram: the four header
//   fields, the saturating byte count, a header flag and a checksum flag.
//   Throughput is one byte per cycle, sustained across datagram boundaries
//   while the result channel keeps up. From the transfer of the last byte,
//   the result passes the input register, the accumulator record, the stage
//   register with the partial sums, then the add and fold into the result register.
//   When the receiver stalls, results collect in the pipeline registers;
//   item_ready drops only when a last byte has nowhere to go, while ordinary
//   bytes keep flowing into the accumulator.
//   A synchronous reset clears the byte count, the running sum, the captured
//   header and all valid flags; no transfer is in flight afterward.
// ----------------------------------------------------------------------------
module udp_datagram_checker
  import udc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  udc_item_t   item,
  output logic        result_valid,
  input  logic        result_ready,
  output udc_result_t result
);

  logic       held_valid;
  udc_item_t  held_item;
  logic       acc_ready;
  logic       down_free;
  logic       dgram_valid;
  udc_dgram_t dgram;

  assign item_ready = !held_valid || acc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held_item <= item;
    end
  end

  udc_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (held_valid),
    .item        (held_item),
    .item_ready  (acc_ready),
    .down_free   (down_free),
    .dgram_valid (dgram_valid),
    .dgram       (dgram)
  );

  udc_final u_final (
    .clk          (clk),
    .rst          (rst),
    .dgram_valid  (dgram_valid),
    .dgram        (dgram),
    .down_free    (down_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

FILE: rtl/core/udc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udc_checker
// Port-level checks on the result channel of the UDP datagram checker.
// ----------------------------------------------------------------------------
module udc_checker
  import udc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input udc_result_t result
);

  // A stalled result keeps its contents until the transfer.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_header_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.header_ok |->
      result.received_count >= UDP_HDR_BYTES && result.length_field >= UDP_HDR_BYTES
      && result.length_field <= result.received_count)
    else $error("header flag set on a bad length");

  // A nonzero stored checksum can only verify when the claimed length arrived.
  a_checksum_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.checksum_ok |->
      result.received_count >= UDP_HDR_BYTES
      && (result.stored_checksum == 16'd0
          || result.length_field <= result.received_count))
    else $error("checksum flag set on a short datagram");

endmodule

bind udp_datagram_checker udc_checker u_udc_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

FILE: tb/tb_udp_datagram_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_udp_datagram_checker
// Streams UDP datagrams byte by byte into the checker and compares every
// result transfer against a cycle-free predictor of the header and checksum
// checks. Covers short datagrams, odd and sub-header lengths, lengths beyond
// the received count, stored zero checksums and corrupted payloads.
// Both handshakes are stalled in random bursts.
// ----------------------------------------------------------------------------
module tb_udp_datagram_checker;
  import udc_pkg::*;

  // Predicts one result per datagram from the accepted bytes and checks the
  // result stream against the queue of predictions.
  class udp_csum_scoreboard;
    logic [15:0] count;
    logic [31:0] sum;
    logic [7:0]  held;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] len_f;
    logic [15:0] csum_f;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    udc_result_t predicted_q[$];
    int errors;
    int n_bytes;
    int n_dgrams;
    int n_hdr_ok;
    int n_sum_ok;

    function new();
      errors = 0;
      n_bytes = 0;
      n_dgrams = 0;
      n_hdr_ok = 0;
      n_sum_ok = 0;
      clear();
    endfunction

    function void clear();
      count = '0;
      sum = '0;
      held = '0;
      sport = '0;
      dport = '0;
      len_f = '0;
      csum_f = '0;
      src_addr = '0;
      dst_addr = '0;
    endfunction

    static function logic [31:0] fold16(logic [31:0] s);
      while (s[31:16] != 16'd0) s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      return s;
    endfunction

    static function logic [15:0] place_byte(logic [15:0] w, logic lo, logic [7:0] b);
      return lo ? {w[15:8], b} : {b, w[7:0]};
    endfunction

    // Header words that lie inside the claimed length; a split word keeps
    // only its high byte.
    function logic [31:0] header_words();
      logic [15:0] words [4];
      logic [31:0] s;
      words[0] = sport;
      words[1] = dport;
      words[2] = len_f;
      words[3] = csum_f;
      s = '0;
      for (int k = 0; k < 4; k++) begin
        if (32'(len_f) >= 2 * k + 2) s = s + 32'(words[k]);
        else if (32'(len_f) == 2 * k + 1) s = s + 32'({words[k][15:8], 8'd0});
      end
      return s;
    endfunction

    function void note_byte(udc_item_t it);
      logic [15:0] idx;
      logic [31:0] s;
      udc_result_t want;
      idx = count;
      n_bytes++;
      if (idx == 16'd0) begin
        src_addr = it.source_address;
        dst_addr = it.destination_address;
      end
      if (idx < 16'd2) sport = place_byte(sport, idx[0], it.data_byte);
      else if (idx < 16'd4) dport = place_byte(dport, idx[0], it.data_byte);
      else if (idx < 16'd6) len_f = place_byte(len_f, idx[0], it.data_byte);
      else if (idx < UDP_HDR_BYTES) csum_f = place_byte(csum_f, idx[0], it.data_byte);
      else if (idx < len_f) begin
        if (!idx[0]) held = it.data_byte;
        else sum = sum + {16'd0, held, it.data_byte};
      end
      if (count != COUNT_MAX) count = count + 16'd1;
      if (!it.last_byte) return;

      want.header_ok = (count >= UDP_HDR_BYTES) && (len_f >= UDP_HDR_BYTES) &&
                       (len_f <= count);
      if (count < UDP_HDR_BYTES) want.checksum_ok = 1'b0;
      else if (csum_f == 16'd0) want.checksum_ok = 1'b1;
      else if (len_f > count) want.checksum_ok = 1'b0;
      else begin
        s = sum;
        if (len_f > UDP_HDR_BYTES && len_f[0]) s = s + {16'd0, held, 8'd0};
        s = fold16(s);
        s = s + header_words();
        s = s + 32'(src_addr[31:16]) + 32'(src_addr[15:0])
              + 32'(dst_addr[31:16]) + 32'(dst_addr[15:0]);
        s = s + 32'(UDP_PROTO) + 32'(len_f);
        want.checksum_ok = (fold16(s) == {16'd0, WORD_MASK});
      end
      want.source_port = sport;
      want.destination_port = dport;
      want.length_field = len_f;
      want.stored_checksum = csum_f;
      want.received_count = count;
      predicted_q.push_back(want);
      if (want.header_ok) n_hdr_ok++;
      if (want.checksum_ok) n_sum_ok++;
      clear();
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(udc_result_t got);
      udc_result_t want;
      if (predicted_q.size() == 0) begin
        $display("%0t: result with no datagram outstanding, expected none, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = predicted_q.pop_front();
      n_dgrams++;
      compare_field("header_ok", 16'(want.header_ok), 16'(got.header_ok));
      compare_field("checksum_ok", 16'(want.checksum_ok), 16'(got.checksum_ok));
      compare_field("source_port", want.source_port, got.source_port);
      compare_field("destination_port", want.destination_port, got.destination_port);
      compare_field("length_field", want.length_field, got.length_field);
      compare_field("stored_checksum", want.stored_checksum, got.stored_checksum);
      compare_field("received_count", want.received_count, got.received_count);
    endfunction

    function int pending();
      return predicted_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  udc_item_t   item;
  logic        result_valid;
  logic        result_ready;
  udc_result_t result;

  udp_csum_scoreboard sb = new();
  logic [7:0] dgram_q[$];
  bit         quiet = 1'b0;
  int         items_sent = 0;
  int         stall_left = 0;

  udp_datagram_checker dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("** udp_datagram_checker: FAILED **");
    $finish;
  end

  // Receiver: stalls in short bursts except during the final quiet stretch.
  initial begin
    result_ready = 1'b0;
    forever @(negedge clk) begin
      if (rst) result_ready <= 1'b0;
      else if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  task automatic send_byte(udc_item_t it);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk);
        item_valid <= 1'b0;
      end
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    sb.note_byte(it);
    items_sent++;
  endtask

  // Holds the sender off until every predicted result has been seen.
  task automatic wait_for_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Fills dgram_q with n random bytes carrying the given length field and,
  // when asked and the length allows, a correct checksum.
  function automatic void build_dgram(int unsigned n, logic [15:0] len, bit fix_sum,
                                      logic [31:0] src, logic [31:0] dst);
    logic [31:0] s;
    logic [15:0] c;
    dgram_q.delete();
    for (int unsigned i = 0; i < n; i++) dgram_q.push_back(8'($urandom));
    if (n > 5) begin
      dgram_q[4] = len[15:8];
      dgram_q[5] = len[7:0];
    end
    if (fix_sum && len >= UDP_HDR_BYTES && 32'(len) <= n) begin
      dgram_q[6] = 8'd0;
      dgram_q[7] = 8'd0;
      s = 32'(src[31:16]) + 32'(src[15:0]) + 32'(dst[31:16]) + 32'(dst[15:0])
        + 32'(UDP_PROTO) + 32'(len);
      for (int unsigned i = 0; i < 32'(len); i += 2)
        s = s + 32'({dgram_q[i], (i + 1 < 32'(len)) ? dgram_q[i + 1] : 8'd0});
      s = udp_csum_scoreboard::fold16(s);
      c = ~s[15:0];
      if (c == 16'd0) c = WORD_MASK;
      dgram_q[6] = c[15:8];
      dgram_q[7] = c[7:0];
    end
  endfunction

  // Addresses only count on the first byte; the rest carry noise.
  task automatic send_dgram(logic [31:0] src, logic [31:0] dst);
    udc_item_t it;
    for (int i = 0; i < dgram_q.size(); i++) begin
      it.data_byte = dgram_q[i];
      it.last_byte = (i == dgram_q.size() - 1);
      it.source_address = (i == 0) ? src : $urandom;
      it.destination_address = (i == 0) ? dst : $urandom;
      send_byte(it);
    end
  endtask

  function automatic logic [31:0] pick_address();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 3) return 32'h0000_0000;
    if (r < 6) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic random_dgram();
    int unsigned pick;
    int unsigned n;
    int unsigned pos;
    logic [15:0] len;
    logic [31:0] src;
    logic [31:0] dst;
    pick = $urandom_range(0, 99);
    src = pick_address();
    dst = pick_address();
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 200) : $urandom_range(8, 32);
    len = 16'(n);
    if (pick < 65) begin
      // Well formed, sometimes with trailing bytes past the claimed length.
      if ($urandom_range(0, 9) == 0) len = 16'($urandom_range(8, n));
      build_dgram(n, len, 1'b1, src, dst);
    end else if (pick < 75) begin
      build_dgram(n, 16'($urandom_range(0, n + 4)), 1'b0, src, dst);
      dgram_q[6] = 8'd0;
      dgram_q[7] = 8'd0;
    end else if (pick < 85) begin
      build_dgram(n, len, 1'b1, src, dst);
      pos = $urandom_range(0, n - 1);
      dgram_q[pos] = dgram_q[pos] ^ (8'h01 << $urandom_range(0, 7));
    end else if (pick < 93) begin
      build_dgram($urandom_range(1, 7), 16'($urandom), 1'b0, src, dst);
    end else begin
      case ($urandom_range(0, 2))
        0: len = 16'h0000;
        1: len = 16'hFFFF;
        default: len = 16'($urandom);
      endcase
      build_dgram(n, len, 1'b0, src, dst);
    end
    send_dgram(src, dst);
  endtask

  initial begin
    int start_items;
    int n_random;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: one-byte datagram with all-ones content and addresses.
    dgram_q = '{8'hFF};
    send_dgram(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Odd length, zero addresses, checksum computed before the first byte is cleared.
    build_dgram(9, 16'd9, 1'b1, 32'h0, 32'h0);
    dgram_q[0] = 8'h00;
    send_dgram(32'h0, 32'h0);
    // Length below the header size with a nonzero checksum.
    build_dgram(8, 16'd5, 1'b0, 32'hC0A8_0001, 32'h0A00_00FE);
    dgram_q[7] = 8'h5A;
    send_dgram(32'hC0A8_0001, 32'h0A00_00FE);
    // Length beyond the received count with a stored zero checksum.
    build_dgram(8, 16'd20, 1'b0, 32'h1234_5678, 32'h9ABC_DEF0);
    dgram_q[6] = 8'd0;
    dgram_q[7] = 8'd0;
    send_dgram(32'h1234_5678, 32'h9ABC_DEF0);
    wait_for_results();

    start_items = items_sent;
    n_random = 0;
    while (items_sent - start_items < 700 || n_random < 40) begin
      if (n_random == 20) wait_for_results();
      if (items_sent - start_items > 550) quiet = 1'b1;
      random_dgram();
      n_random++;
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    $display("Checked %0d datagrams from %0d bytes, directed corner cases and random traffic.",
             sb.n_dgrams, sb.n_bytes);
    $display("Header valid in %0d of them, checksum accepted in %0d.",
             sb.n_hdr_ok, sb.n_sum_ok);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** udp_datagram_checker: PASSED **");
    end else begin
      $display("** udp_datagram_checker: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/udc_pkg.sv
rtl/core/udc_accum.sv
rtl/core/udc_final.sv
rtl/core/udp_datagram_checker.sv
rtl/core/udc_checker.sv
tb/tb_udp_datagram_checker.sv
